>>> hdl/pli_pkg.sv
`timescale 1ns / 1ps

package pli_pkg;

    localparam int IDX_W    = 4;
    localparam int VAL_W    = 32;
    localparam int DIV_BITS = 35;
    localparam int CNT_W    = $clog2(DIV_BITS);
    localparam int PROD_W   = 2 * VAL_W;

    localparam logic OP_EVAL = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic [DIV_BITS-1:0] SAT_LIMIT = DIV_BITS'(64'h2_0000_0000);
    localparam logic [VAL_W-1:0]    VAL_MAX   = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0]    VAL_MIN   = 32'h8000_0000;

    typedef enum logic [1:0] {
        KIND_EVAL,
        KIND_LOAD,
        KIND_DROP
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
    } item_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHK0,
        BK_SRCH,
        BK_CALC,
        BK_MUL,
        BK_DCHK,
        BK_DIV,
        BK_FIN
    } bk_state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic idle;
        logic dividing;
    } bk_status_t;

endpackage

>>> hdl/pli_ram.sv
`timescale 1ns / 1ps

module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 10,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/pli_front.sv
`timescale 1ns / 1ps

module pli_front #(
    parameter int POINTS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         operation,
    input  logic [pli_pkg::IDX_W-1:0]    point_index,
    input  logic signed [pli_pkg::VAL_W-1:0] x_value,
    input  logic signed [pli_pkg::VAL_W-1:0] y_value,
    output pli_pkg::item_t               item,
    output logic                         item_valid,
    input  logic                         item_ready,
    output pli_pkg::q_status_t           status
);

    import pli_pkg::*;

    item_t      ent_reg [2];
    item_t      ent_next [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    item_t      cls;

    always_comb
    begin
        cls.idx = point_index;
        cls.x   = x_value;
        cls.y   = y_value;
        unique case (operation)
            OP_LOAD: cls.kind = (int'(point_index) < POINTS) ? KIND_LOAD : KIND_DROP;
            OP_EVAL: cls.kind = KIND_EVAL;
            default: cls.kind = KIND_DROP;
        endcase
    end

    assign busy       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = ent_reg[rptr_reg];
    assign push       = start && !busy;
    assign pop        = item_valid && item_ready;
    assign status     = '{empty: (cnt_reg == 2'd0), full: busy};

    always_comb
    begin
        ent_next  = ent_reg;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push)
        begin
            ent_next[wptr_reg] = cls;
            wptr_next          = !wptr_reg;
        end
        if (pop)
        begin
            rptr_next = !rptr_reg;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

>>> hdl/pli_back.sv
`timescale 1ns / 1ps

module pli_back #(
    parameter int POINTS = 10,
    localparam int AW    = $clog2(POINTS)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pli_pkg::item_t                   item,
    input  logic                             item_valid,
    output logic                             item_ready,
    output logic                             result_valid,
    output logic signed [pli_pkg::VAL_W-1:0] result_y,
    output logic [pli_pkg::IDX_W-1:0]        segment,
    output logic                             clamped,
    output pli_pkg::bk_status_t              status
);

    import pli_pkg::*;

    bk_state_t state_reg, state_next;

    logic [POINTS-1:0] vld_reg, vld_next;
    logic              rd_vld_reg, rd_vld_next;

    logic signed [VAL_W-1:0] q_reg, q_next;
    logic signed [VAL_W-1:0] xq_reg, xq_next;
    logic                    clamp_reg, clamp_next;
    logic signed [VAL_W-1:0] x0_reg, x0_next;
    logic signed [VAL_W-1:0] y0_reg, y0_next;
    logic signed [VAL_W-1:0] x1_reg, x1_next;
    logic signed [VAL_W-1:0] y1_reg, y1_next;
    logic [AW-1:0]           n_reg, n_next;
    logic [VAL_W-1:0]        dxm_reg, dxm_next;
    logic [VAL_W-1:0]        dym_reg, dym_next;
    logic [VAL_W-1:0]        mxm_reg, mxm_next;
    logic                    neg_reg, neg_next;
    logic                    mxz_reg, mxz_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    sat_reg, sat_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [DIV_BITS-1:0]     dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    res_vld_reg, res_vld_next;
    logic signed [VAL_W-1:0] res_y_reg, res_y_next;
    logic [IDX_W-1:0]        res_seg_reg, res_seg_next;
    logic                    res_clp_reg, res_clp_next;

    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [2*VAL_W-1:0]      ram_q;
    logic signed [VAL_W-1:0] rd_x, rd_y;

    logic signed [VAL_W:0]   dx_w, mx_w, dy_w;
    logic [VAL_W:0]          dx_a, mx_a, dy_a;
    logic [VAL_W:0]          div_t;
    logic                    div_ge;
    logic signed [VAL_W+3:0] sum_w;
    logic [AW:0]             n_plus2;

    pli_ram #(
        .WIDTH(2 * VAL_W),
        .DEPTH(POINTS)
    ) u_tbl (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata({item.x, item.y}),
        .raddr(ram_raddr),
        .rdata(ram_q)
    );

    assign rd_x = rd_vld_reg ? $signed(ram_q[2*VAL_W-1:VAL_W]) : '0;
    assign rd_y = rd_vld_reg ? $signed(ram_q[VAL_W-1:0]) : '0;

    assign dx_w = {xq_reg[VAL_W-1], xq_reg} - {x0_reg[VAL_W-1], x0_reg};
    assign mx_w = {x1_reg[VAL_W-1], x1_reg} - {x0_reg[VAL_W-1], x0_reg};
    assign dy_w = {y1_reg[VAL_W-1], y1_reg} - {y0_reg[VAL_W-1], y0_reg};
    assign dx_a = dx_w[VAL_W] ? (VAL_W+1)'(-dx_w) : dx_w;
    assign mx_a = mx_w[VAL_W] ? (VAL_W+1)'(-mx_w) : mx_w;
    assign dy_a = dy_w[VAL_W] ? (VAL_W+1)'(-dy_w) : dy_w;

    assign div_t  = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign div_ge = (div_t >= {1'b0, mxm_reg});

    assign sum_w = neg_reg ? ((VAL_W+4)'(y0_reg) - $signed({1'b0, quot_reg}))
                           : ((VAL_W+4)'(y0_reg) + $signed({1'b0, quot_reg}));

    assign n_plus2 = (AW+1)'(n_reg) + (AW+1)'(2);

    assign item_ready   = (state_reg == BK_IDLE);
    assign result_valid = res_vld_reg;
    assign result_y     = res_y_reg;
    assign segment      = res_seg_reg;
    assign clamped      = res_clp_reg;
    assign status       = '{idle: (state_reg == BK_IDLE), dividing: (state_reg == BK_DIV)};

    always_comb
    begin
        state_next   = state_reg;
        vld_next     = vld_reg;
        q_next       = q_reg;
        xq_next      = xq_reg;
        clamp_next   = clamp_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        n_next       = n_reg;
        dxm_next     = dxm_reg;
        dym_next     = dym_reg;
        mxm_next     = mxm_reg;
        neg_next     = neg_reg;
        mxz_next     = mxz_reg;
        prod_next    = prod_reg;
        sat_next     = sat_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quot_next    = quot_reg;
        cnt_next     = cnt_reg;
        res_vld_next = 1'b0;
        res_y_next   = res_y_reg;
        res_seg_next = res_seg_reg;
        res_clp_next = res_clp_reg;
        ram_we       = 1'b0;
        ram_waddr    = AW'(item.idx);
        ram_raddr    = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.kind)
                        KIND_LOAD:
                        begin
                            ram_we                = 1'b1;
                            vld_next[AW'(item.idx)] = 1'b1;
                        end
                        KIND_EVAL:
                        begin
                            q_next     = item.x;
                            xq_next    = item.x;
                            clamp_next = 1'b0;
                            state_next = BK_CHK0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_CHK0:
            begin
                if (q_reg < rd_x)
                begin
                    res_vld_next = 1'b1;
                    res_y_next   = rd_y;
                    res_seg_next = '0;
                    res_clp_next = 1'b1;
                    state_next   = BK_IDLE;
                end
                else
                begin
                    x0_next    = rd_x;
                    y0_next    = rd_y;
                    n_next     = '0;
                    ram_raddr  = AW'(1);
                    state_next = BK_SRCH;
                end
            end
            BK_SRCH:
            begin
                ram_raddr = AW'(n_plus2);
                if (q_reg < rd_x)
                begin
                    x1_next    = rd_x;
                    y1_next    = rd_y;
                    state_next = BK_CALC;
                end
                else if (int'(n_reg) == POINTS - 2)
                begin
                    x1_next = rd_x;
                    y1_next = rd_y;
                    if (q_reg > rd_x)
                    begin
                        xq_next    = rd_x;
                        clamp_next = 1'b1;
                    end
                    state_next = BK_CALC;
                end
                else
                begin
                    x0_next = rd_x;
                    y0_next = rd_y;
                    n_next  = n_reg + AW'(1);
                end
            end
            BK_CALC:
            begin
                dxm_next   = dx_a[VAL_W-1:0];
                dym_next   = dy_a[VAL_W-1:0];
                mxm_next   = mx_a[VAL_W-1:0];
                mxz_next   = (mx_w == '0);
                neg_next   = (dx_w == '0 || dy_w == '0) ? 1'b0
                                : (dx_w[VAL_W] ^ dy_w[VAL_W] ^ mx_w[VAL_W]);
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                prod_next  = dxm_reg * dym_reg;
                state_next = mxz_reg ? BK_FIN : BK_DCHK;
            end
            BK_DCHK:
            begin
                sat_next  = (VAL_W'(prod_reg[PROD_W-1:DIV_BITS]) >= mxm_reg);
                rem_next  = VAL_W'(prod_reg[PROD_W-1:DIV_BITS]);
                dvd_next  = prod_reg[DIV_BITS-1:0];
                quot_next = '0;
                cnt_next  = CNT_W'(DIV_BITS - 1);
                state_next = (VAL_W'(prod_reg[PROD_W-1:DIV_BITS]) >= mxm_reg) ? BK_FIN
                                                                               : BK_DIV;
            end
            BK_DIV:
            begin
                rem_next  = div_ge ? VAL_W'(div_t - {1'b0, mxm_reg}) : div_t[VAL_W-1:0];
                quot_next = {quot_reg[DIV_BITS-2:0], div_ge};
                dvd_next  = {dvd_reg[DIV_BITS-2:0], 1'b0};
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = BK_FIN;
                end
            end
            BK_FIN:
            begin
                res_vld_next = 1'b1;
                res_seg_next = IDX_W'(n_reg);
                res_clp_next = clamp_reg;
                if (mxz_reg)
                begin
                    res_y_next = y0_reg;
                end
                else if (sat_reg || quot_reg > SAT_LIMIT)
                begin
                    res_y_next = neg_reg ? VAL_MIN : VAL_MAX;
                end
                else if (sum_w[VAL_W+3:VAL_W-1] != {5{sum_w[VAL_W+3]}})
                begin
                    res_y_next = sum_w[VAL_W+3] ? VAL_MIN : VAL_MAX;
                end
                else
                begin
                    res_y_next = sum_w[VAL_W-1:0];
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        rd_vld_next = (int'(ram_raddr) < POINTS) ? vld_next[ram_raddr] : 1'b0;
        if (int'(ram_raddr) < POINTS)
        begin
            rd_vld_next = vld_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vld_reg     <= vld_next;
            rd_vld_reg  <= rd_vld_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        xq_reg      <= xq_next;
        clamp_reg   <= clamp_next;
        x0_reg      <= x0_next;
        y0_reg      <= y0_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        n_reg       <= n_next;
        dxm_reg     <= dxm_next;
        dym_reg     <= dym_next;
        mxm_reg     <= mxm_next;
        neg_reg     <= neg_next;
        mxz_reg     <= mxz_next;
        prod_reg    <= prod_next;
        sat_reg     <= sat_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quot_reg    <= quot_next;
        cnt_reg     <= cnt_next;
        res_y_reg   <= res_y_next;
        res_seg_reg <= res_seg_next;
        res_clp_reg <= res_clp_next;
    end

endmodule

>>> hdl/piecewise_linear_interpolator_core.sv
`timescale 1ns / 1ps

// Piecewise linear interpolation table of POINTS breakpoints in signed Q16.16. Items enter
// through a two-deep queue; busy is high only while that queue is full, and the block reads
// its table through one registered port, so items are carried out one at a time. A load
// item leaves the queue and writes its breakpoint, or is dropped if its index is POINTS or
// more. An evaluate item whose query lies below the first x ends after a first-breakpoint
// check; otherwise it runs that check, a search step per breakpoint up to the upper end of
// the segment, a setup step, a multiply step, a range check, the one-bit-per-cycle restoring
// divider, a final step and the result cycle. A zero-width segment skips the range check and
// the divide, and a quotient found out of range at the check skips the divide. Each result
// shows on result_y, segment and clamped for exactly one cycle while result_valid is high;
// the receiver cannot stall it. The table reads as all zero after reset.
module piecewise_linear_interpolator_core #(
    parameter int POINTS = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic [pli_pkg::IDX_W-1:0]        point_index,
    input  logic signed [pli_pkg::VAL_W-1:0] x_value,
    input  logic signed [pli_pkg::VAL_W-1:0] y_value,
    output logic                             result_valid,
    output logic signed [pli_pkg::VAL_W-1:0] result_y,
    output logic [pli_pkg::IDX_W-1:0]        segment,
    output logic                             clamped
);

    import pli_pkg::*;

    item_t      item;
    logic       item_valid;
    logic       item_ready;
    q_status_t  q_status;
    bk_status_t bk_status;

    pli_front #(
        .POINTS(POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .operation  (operation),
        .point_index(point_index),
        .x_value    (x_value),
        .y_value    (y_value),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (q_status)
    );

    pli_back #(
        .POINTS(POINTS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .result_valid(result_valid),
        .result_y    (result_y),
        .segment     (segment),
        .clamped     (clamped),
        .status      (bk_status)
    );

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(!bk_status.idle))
        else $error("result appeared without an item in progress");

    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.empty && q_status.full))
        else $error("queue both empty and full");

    a_quiet_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        bk_status.dividing |-> !result_valid)
        else $error("result strobe during divide");

endmodule
